// ===== hw/rtl/mps_pkg.sv =====
// ---------------------------------------------------------------------------
// mps_pkg: shared definitions for the max pooling stream
// Sizes, register indexes, control structs and small helper functions.
// ---------------------------------------------------------------------------
package mps_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_WINDOW = 4;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int BANK_W     = $clog2(MAX_WINDOW);
	localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
	localparam int ROW_W      = 12;
	localparam int STEP_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int NUM_REGS   = 5;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_HEIGHT    = 3'd0,
		REG_MAP_WIDTH     = 3'd1,
		REG_WINDOW_HEIGHT = 3'd2,
		REG_WINDOW_WIDTH  = 3'd3,
		REG_STEP_SIZE     = 3'd4
	} cfg_reg_t;

	// line store bank port control
	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [COL_W-1:0] addr;
	} bank_ctl_t;

	// pooling cell control
	typedef struct packed {
		logic shift_en;
		logic in_window;
	} cell_ctl_t;

	// zero acts as one, oversize saturates
	function automatic logic [WIN_W-1:0] win_eff(input logic [2:0] v);
		if (v == 3'd0) begin
			return WIN_W'(1);
		end else if (int'(v) > MAX_WINDOW) begin
			return WIN_W'(MAX_WINDOW);
		end else begin
			return WIN_W'(v);
		end
	endfunction

	function automatic logic [COL_W:0] width_eff(input logic [8:0] v);
		if (v == 9'd0) begin
			return (COL_W+1)'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			return (COL_W+1)'(MAX_WIDTH);
		end else begin
			return (COL_W+1)'(v);
		end
	endfunction

	// x mod st for small x (x < MAX_WINDOW), st >= 1
	function automatic logic [STEP_W-1:0] small_mod(input logic [WIN_W-1:0] x,
		input logic [STEP_W-1:0] st);
		logic [WIN_W:0] acc;
		acc = {1'b0, x};
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (acc >= (WIN_W+1)'(st)) begin
				acc = acc - (WIN_W+1)'(st);
			end
		end
		return STEP_W'(acc);
	endfunction

endpackage

// ===== hw/rtl/max_pooling_stream.sv =====
// ---------------------------------------------------------------------------
// max_pooling_stream: strided 2-D max pooling over a raster sample stream
// Top level: counters, line store banks, column max and pooling cell chain.
// ---------------------------------------------------------------------------
// Takes one signed sample per cycle in raster order, one map after another,
// and returns the maximum of every window_height x window_width window whose
// top-left corner sits on the step_size grid and which lies inside the map.
// The last window of each map carries last_of_map. Throughput is one sample
// per clock unless a stalled output holds the pipeline. A result passes the
// line store read at the edge that takes its sample, then the column max
// register and the output register. The line store is
// MAX_WINDOW banks of MAX_WIDTH samples, one row each, all read at the same
// column every beat; no clearing pass is needed after reset. Writing any
// configuration register restarts the map at row 0, column 0. Zero sizes act
// as one; map_width saturates at MAX_WIDTH and the window at MAX_WINDOW.
// cfg_ready is always high; write registers only while the block is idle.
// ---------------------------------------------------------------------------
module max_pooling_stream
	import mps_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,

	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,

	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] sample_value,

	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] pooled_value,
	output logic                         last_of_map
);

	// ---------------- configuration registers ----------------
	logic [ROW_W-1:0]  map_height_q;
	logic [8:0]        map_width_q;
	logic [2:0]        win_h_q;
	logic [2:0]        win_w_q;
	logic [STEP_W-1:0] step_q;
	logic              cfg_hit;

	assign cfg_ready = 1'b1;
	// only listed registers restart the map
	assign cfg_hit   = cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_height_q <= ROW_W'(28);
			map_width_q  <= 9'd28;
			win_h_q      <= 3'd2;
			win_w_q      <= 3'd2;
			step_q       <= STEP_W'(2);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAP_HEIGHT:    map_height_q <= cfg_data[ROW_W-1:0];
				REG_MAP_WIDTH:     map_width_q  <= cfg_data[8:0];
				REG_WINDOW_HEIGHT: win_h_q      <= cfg_data[2:0];
				REG_WINDOW_WIDTH:  win_w_q      <= cfg_data[2:0];
				REG_STEP_SIZE:     step_q       <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [ROW_W-1:0]  h_eff;
	logic [COL_W:0]    w_eff;
	logic [WIN_W-1:0]  wh_eff;
	logic [WIN_W-1:0]  ww_eff;
	logic [STEP_W-1:0] st_eff;
	logic [STEP_W-1:0] row_phase_hit;   // r mod st that puts top on the grid
	logic [STEP_W-1:0] col_phase_hit;

	assign h_eff  = (map_height_q == '0) ? ROW_W'(1) : map_height_q;
	assign w_eff  = width_eff(map_width_q);
	assign wh_eff = win_eff(win_h_q);
	assign ww_eff = win_eff(win_w_q);
	assign st_eff = (step_q == '0) ? STEP_W'(1) : step_q;
	assign row_phase_hit = small_mod(wh_eff - WIN_W'(1), st_eff);
	assign col_phase_hit = small_mod(ww_eff - WIN_W'(1), st_eff);

	// ---------------- handshake / pipeline control ----------------
	logic v_s1, v_s2, out_valid_q;
	logic emit_s1, emit_s2, last_s1, last_s2;
	logic can_out, s2_go, s2_free, s1_go, accept, out_load;

	assign can_out  = !out_valid_q || out_ready;
	assign s2_go    = v_s2 && (!emit_s2 || can_out);
	assign s2_free  = !v_s2 || s2_go;
	assign s1_go    = v_s1 && s2_free;
	assign in_ready = !v_s1 || s1_go;
	assign accept   = in_valid && in_ready;
	assign out_load = s2_go && emit_s2;

	// ---------------- position counters ----------------
	logic [ROW_W-1:0]  row_q, row_n, row_cur;
	logic [COL_W-1:0]  col_q, col_n, col_cur;
	logic [STEP_W-1:0] rph_q, rph_n, rph_cur;   // row mod step
	logic [STEP_W-1:0] cph_q, cph_n, cph_cur;   // col mod step
	logic [BANK_W-1:0] bank_q, bank_n, bank_cur; // row mod MAX_WINDOW
	logic              in_range, col_wrap, row_wrap;
	logic              emit_cur, last_cur;

	assign in_range = (row_q < h_eff) && ((COL_W+1)'(col_q) < w_eff);
	assign row_cur  = in_range ? row_q  : '0;
	assign col_cur  = in_range ? col_q  : '0;
	assign rph_cur  = in_range ? rph_q  : '0;
	assign cph_cur  = in_range ? cph_q  : '0;
	assign bank_cur = in_range ? bank_q : '0;

	assign col_wrap = ((COL_W+1)'(col_cur) + (COL_W+1)'(1)) >= w_eff;
	assign row_wrap = ((ROW_W+1)'(row_cur) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);

	always_comb begin
		row_n  = row_cur;
		rph_n  = rph_cur;
		bank_n = bank_cur;
		if (col_wrap) begin
			col_n = '0;
			cph_n = '0;
			if (row_wrap) begin
				row_n  = '0;
				rph_n  = '0;
				bank_n = '0;
			end else begin
				row_n  = row_cur + ROW_W'(1);
				rph_n  = (rph_cur + STEP_W'(1) == st_eff) ? '0 : rph_cur + STEP_W'(1);
				bank_n = (int'(bank_cur) == MAX_WINDOW - 1) ? '0 : bank_cur + BANK_W'(1);
			end
		end else begin
			col_n = col_cur + COL_W'(1);
			cph_n = (cph_cur + STEP_W'(1) == st_eff) ? '0 : cph_cur + STEP_W'(1);
		end
	end

	// window completes here and its corner is on the grid
	assign emit_cur = (((ROW_W+1)'(row_cur) + (ROW_W+1)'(1)) >= (ROW_W+1)'(wh_eff))
		&& (((COL_W+1)'(col_cur) + (COL_W+1)'(1)) >= (COL_W+1)'(ww_eff))
		&& (ROW_W'(wh_eff) <= h_eff)
		&& ((COL_W+1)'(ww_eff) <= w_eff)
		&& (rph_cur == row_phase_hit)
		&& (cph_cur == col_phase_hit);

	// last grid window: no further corner fits before the map edge
	assign last_cur = (((ROW_W+1)'(row_cur) + (ROW_W+1)'(st_eff)) >= (ROW_W+1)'(h_eff))
		&& (((COL_W+4)'(col_cur) + (COL_W+4)'(st_eff)) >= (COL_W+4)'(w_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			bank_q <= '0;
		end else if (cfg_hit) begin
			row_q  <= '0;
			col_q  <= '0;
			rph_q  <= '0;
			cph_q  <= '0;
			bank_q <= '0;
		end else if (accept) begin
			row_q  <= row_n;
			col_q  <= col_n;
			rph_q  <= rph_n;
			cph_q  <= cph_n;
			bank_q <= bank_n;
		end
	end

	// ---------------- line store ----------------
	// Every bank reads the current column each beat; the sample's own row
	// bank is written at the same edge. Older rows sit in the other banks.
	data_t rd_data [MAX_WINDOW];

	for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
		bank_ctl_t bank_ctl;

		assign bank_ctl.wr_en = accept && (int'(bank_cur) == b);
		assign bank_ctl.rd_en = accept;
		assign bank_ctl.addr  = col_cur;

		mps_line_bank u_bank (
			.clk     (clk),
			.ctl     (bank_ctl),
			.wr_data (sample_value),
			.rd_data (rd_data[b])
		);
	end

	// ---------------- stage 1: column max ----------------
	data_t             sample_s1;
	logic [BANK_W-1:0] bank_s1;
	data_t             colmax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_value;
			bank_s1   <= bank_cur;
			emit_s1   <= emit_cur;
			last_s1   <= last_cur;
		end
	end

	// rows r-1 .. r-wh+1 live in the banks just behind the current one
	always_comb begin
		logic [BANK_W-1:0] idx;
		colmax = sample_s1;
		idx    = '0;
		for (int k = 1; k < MAX_WINDOW; k++) begin
			if (int'(bank_s1) >= k) begin
				idx = BANK_W'(int'(bank_s1) - k);
			end else begin
				idx = BANK_W'(int'(bank_s1) + MAX_WINDOW - k);
			end
			if ((k < int'(wh_eff)) && (rd_data[idx] > colmax)) begin
				colmax = rd_data[idx];
			end
		end
	end

	// ---------------- stage 2: pooling cell chain ----------------
	data_t colmax_s2;
	data_t part    [MAX_WINDOW];
	data_t col_tap [MAX_WINDOW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_go) begin
			v_s2 <= 1'b1;
		end else if (s2_go) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			colmax_s2 <= colmax;
			emit_s2   <= emit_s1;
			last_s2   <= last_s1;
		end
	end

	// cell k holds the column max k+1 beats back; the chain folds in
	// as many columns as the window is wide
	assign part[0]    = colmax_s2;
	assign col_tap[0] = colmax_s2;

	for (genvar k = 0; k < MAX_WINDOW - 1; k++) begin : g_cell
		cell_ctl_t cell_ctl;

		assign cell_ctl.shift_en  = s2_go;
		assign cell_ctl.in_window = (k + 1) < int'(ww_eff);

		mps_pool_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.col_in   (col_tap[k]),
			.part_in  (part[k]),
			.col_out  (col_tap[k+1]),
			.part_out (part[k+1])
		);
	end

	// ---------------- output register ----------------
	data_t pooled_q;
	logic  last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pooled_q <= part[MAX_WINDOW-1];
			last_q   <= last_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign pooled_value = pooled_q;
	assign last_of_map  = last_q;

	// ---------------- assertions ----------------
`ifndef ASSERT_OFF
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (row_q == '0) && (col_q == '0) && (bank_q == '0))
		else $error("config write did not restart the map");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q < h_eff) && ((COL_W+1)'(col_q) < w_eff))
		else $error("position counter outside the map");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rph_q < st_eff) && (cph_q < st_eff))
		else $error("stride phase outside the step");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> !$past(out_load) || $stable(pooled_q))
		else $error("result overwritten while waiting");
`endif

endmodule

// ===== hw/rtl/mps_line_bank.sv =====
// ---------------------------------------------------------------------------
// mps_line_bank: one row of the line store
// Single write port, single registered read port, one column per entry.
// ---------------------------------------------------------------------------
module mps_line_bank
	import mps_pkg::*;
(
	input  logic      clk,
	input  bank_ctl_t ctl,
	input  data_t     wr_data,
	output data_t     rd_data
);

	data_t mem [MAX_WIDTH];
	data_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/mps_pool_cell.sv =====
// ---------------------------------------------------------------------------
// mps_pool_cell: one column slot of the horizontal pooling chain
// Holds an earlier column maximum, passes it on, folds it into the partial max.
// ---------------------------------------------------------------------------
module mps_pool_cell
	import mps_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  data_t     col_in,
	input  data_t     part_in,
	output data_t     col_out,
	output data_t     part_out
);

	data_t col_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out  = col_q;
	assign part_out = (ctl.in_window && (col_q > part_in)) ? col_q : part_in;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for max_pooling_stream
// Streams signed samples through several map, window and stride settings,
// predicts every pooled beat with an independent line store model and
// compares value and last-of-map flag in order against the block's output.
// ---------------------------------------------------------------------------
module tb;
	import mps_pkg::*;

	// give the pipeline room to empty before a reg write
	localparam int DRAIN_CYCLES = 8;
	// cycles with no beat on any channel before the run is declared hung
	localparam int STALL_LIMIT  = 4000;
	// mid-map pause point in the second random run
	localparam int PAUSE_AT     = 50;
	// index past the register file: must neither change a size nor restart the map
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd5;

	typedef struct packed {
		data_t value;
		logic  last;
	} pool_res_t;

	// one directed row: a register write or a sample, optionally with a typed result
	typedef struct packed {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          val;
		bit                   typed;
		logic [15:0]          exp_v;
		bit                   exp_l;
	} dir_row_t;

	typedef struct packed {
		logic [11:0] h;
		logic [11:0] w;
		logic [11:0] wh;
		logic [11:0] ww;
		logic [11:0] st;
		int          n;
	} run_cfg_t;

	localparam dir_row_t DIRECTED [39] = '{
		// 2x2 map, reset window 2x2 stride 2: one window, signed extremes
		'{1'b1, REG_MAP_HEIGHT,    16'd2,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_MAP_WIDTH,     16'd2,    1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h8000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h7FFF, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hFFFF, 1'b1, 16'h7FFF, 1'b1},
		// every size zero: 1x1 map and window, each sample comes straight back
		'{1'b1, REG_MAP_HEIGHT,    16'd0,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_MAP_WIDTH,     16'd0,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_WINDOW_HEIGHT, 16'd0,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_WINDOW_WIDTH,  16'd0,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_STEP_SIZE,     16'd0,    1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h5555, 1'b1, 16'h5555, 1'b1},
		'{1'b0, REG_NONE,          16'hAAAA, 1'b1, 16'hAAAA, 1'b1},
		// oversized window saturates to 4x4, larger than a 1x3 map: nothing out
		'{1'b1, REG_WINDOW_HEIGHT, 16'd7,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_WINDOW_WIDTH,  16'd5,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_STEP_SIZE,     16'd7,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_MAP_HEIGHT,    16'd1,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_MAP_WIDTH,     16'd3,    1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h1234, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hEDCB, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0001, 1'b0, 16'h0000, 1'b0},
		// 4x4 map, full 4x4 window: max sits in the oldest row bank
		'{1'b1, REG_MAP_HEIGHT,    16'd4,    1'b0, 16'h0000, 1'b0},
		'{1'b1, REG_MAP_WIDTH,     16'd4,    1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h8000, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0005, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hFFFF, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h7FFF, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h8001, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0064, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hFF9C, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h7FFE, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0002, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0003, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0004, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h0005, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hFFFB, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hFFFA, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'hFFF9, 1'b0, 16'h0000, 1'b0},
		'{1'b0, REG_NONE,          16'h8000, 1'b1, 16'h7FFF, 1'b1}
	};

	// random runs: map h, map w, window h, window w, stride, sample count
	localparam run_cfg_t RUNS [10] = '{
		'{12'd28,   12'd28,  12'd2,   12'd2,   12'd2, 112},  // reset sizes
		'{12'd6,    12'd7,   12'd3,   12'd2,   12'd1,  84},  // overlapping windows
		'{12'd4095, 12'd1,   12'd1,   12'd1,   12'd3,  40},  // tallest map, one column
		'{12'd1,    12'hFFF, 12'd1,   12'd4,   12'd4, 256},  // width masks, saturates to 256
		'{12'd5,    12'd9,   12'd4,   12'd4,   12'd3,  90},  // edge windows dropped
		'{12'd3,    12'd5,   12'd3,   12'd1,   12'd4,  30},
		'{12'd8,    12'd8,   12'd2,   12'd3,   12'd5,  64},
		'{12'd7,    12'd3,   12'hFFE, 12'h00E, 12'd6,  21},  // window wider than map
		'{12'd3,    12'd3,   12'd3,   12'd3,   12'd1,  27},
		'{12'd2,    12'd16,  12'd2,   12'd2,   12'd2,  64}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	data_t                 sample_value;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	data_t                 pooled_value;
	logic                  last_of_map;

	// typed expectation riding along with the current input beat
	bit    row_typed;
	data_t typed_value;
	bit    typed_last;

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int quiet_cycles = 0;
	int mismatches   = 0;

	pool_res_t pooled_q [$];

	// predictor state: register copies, line store, raster position
	logic [11:0] pm_height = 12'd28;
	logic [8:0]  pm_width  = 9'd28;
	logic [2:0]  pm_win_h  = 3'd2;
	logic [2:0]  pm_win_w  = 3'd2;
	logic [2:0]  pm_step   = 3'd2;
	data_t       line_buf [MAX_WINDOW][MAX_WIDTH];
	int unsigned pos_row = 0;
	int unsigned pos_col = 0;

	max_pooling_stream dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pooled_value (pooled_value),
		.last_of_map  (last_of_map)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// zero acts as one, then clip to the hardware limit
	function automatic int unsigned clip_size(input int unsigned v, input int unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic void cfg_apply(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_MAP_HEIGHT:    pm_height = val[11:0];
			REG_MAP_WIDTH:     pm_width  = val[8:0];
			REG_WINDOW_HEIGHT: pm_win_h  = val[2:0];
			REG_WINDOW_WIDTH:  pm_win_w  = val[2:0];
			REG_STEP_SIZE:     pm_step   = val[2:0];
			default:           return;  // no register, position kept
		endcase
		pos_row = 0;
		pos_col = 0;
	endfunction

	// store one sample; returns 1 with the window max when it closes a window on the grid
	function automatic bit pool_predict(input data_t s, output pool_res_t res);
		int unsigned h, w, wh, ww, st, r, c, top, left;
		data_t       best;
		bit          hit;
		h   = clip_size(pm_height, 32'hFFFF);
		w   = clip_size(pm_width, MAX_WIDTH);
		wh  = clip_size(pm_win_h, MAX_WINDOW);
		ww  = clip_size(pm_win_w, MAX_WINDOW);
		st  = clip_size(pm_step, 32'hFFFF);
		r   = pos_row;
		c   = pos_col;
		hit = 1'b0;
		res = '0;
		if (r >= h || c >= w) begin
			r = 0;
			c = 0;
		end
		line_buf[r % MAX_WINDOW][c] = s;
		if (r + 1 >= wh && c + 1 >= ww && wh <= h && ww <= w) begin
			top  = r + 1 - wh;
			left = c + 1 - ww;
			if (top % st == 0 && left % st == 0) begin
				best = line_buf[top % MAX_WINDOW][left];
				for (int k = 0; k < wh; k++) begin
					for (int l = 0; l < ww; l++) begin
						if (line_buf[(top + k) % MAX_WINDOW][left + l] > best) begin
							best = line_buf[(top + k) % MAX_WINDOW][left + l];
						end
					end
				end
				res.value = best;
				res.last  = (top == ((h - wh) / st) * st) && (left == ((w - ww) / st) * st);
				hit = 1'b1;
			end
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		pos_row = r;
		pos_col = c;
		return hit;
	endfunction

	function automatic data_t rand_sample();
		case ($urandom_range(3))
			0:       return data_t'($urandom_range(15)) - data_t'(8);  // near zero, many ties
			1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			default: return data_t'($urandom);
		endcase
	endfunction

	// receiver back-pressure, changed on the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// monitor: every beat on every channel is seen at the rising edge
	always @(posedge clk) begin
		pool_res_t want;
		pool_res_t got;
		bit        quiet;
		quiet = 1'b1;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				quiet = 1'b0;
				if (pooled_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected beat pooled_value %0d last_of_map %0b",
							$time, pooled_value, last_of_map);
					end
				end else begin
					want = pooled_q.pop_front();
					if (pooled_value !== want.value || last_of_map !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: pooled_value exp %0d got %0d, last_of_map exp %0b got %0b",
								$time, want.value, pooled_value, want.last, last_of_map);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				quiet = 1'b0;
				cfg_apply(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				quiet = 1'b0;
				// typed rows override the predicted value; the predictor still tracks state
				if (pool_predict(sample_value, got) || row_typed) begin
					if (row_typed) begin
						got.value = typed_value;
						got.last  = typed_last;
					end
					pooled_q.push_back(got);
				end
			end
		end
		quiet_cycles = quiet ? quiet_cycles + 1 : 0;
	end

	// hang detector: nothing moved on any channel for too long
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// one sample beat; starts and ends at a falling edge, valid left high
	task automatic send_sample(input data_t v, input bit typed, input data_t tv, input bit tl);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= v;
		row_typed    <= typed;
		typed_value  <= tv;
		typed_last   <= tl;
		do begin
			@(posedge clk);
		end while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending, let every expected beat arrive, then let the pipe empty
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pooled_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		sample_value = '0;
		row_typed    = 1'b0;
		typed_value  = '0;
		typed_last   = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: register writes only on an empty pipe
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg) begin
				wait_drained();
				write_reg(DIRECTED[i].idx, DIRECTED[i].val[11:0]);
			end else begin
				send_sample(DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].exp_v,
					DIRECTED[i].exp_l);
			end
		end

		// random: receiver mostly idle first, then sender, then full rate
		foreach (RUNS[p]) begin
			snd_idle_pct = (p < 4) ? 12 : ((p < 7) ? 75 : 0);
			rcv_idle_pct = (p < 4) ? 75 : ((p < 7) ? 12 : 0);
			wait_drained();
			write_reg(REG_MAP_HEIGHT, RUNS[p].h);
			write_reg(REG_MAP_WIDTH, RUNS[p].w);
			write_reg(REG_WINDOW_HEIGHT, RUNS[p].wh);
			write_reg(REG_WINDOW_WIDTH, RUNS[p].ww);
			write_reg(REG_STEP_SIZE, RUNS[p].st);
			for (int n = 0; n < RUNS[p].n; n++) begin
				if (p == 1 && n == PAUSE_AT) begin
					// mid-map: full drain, then a write to a missing register
					wait_drained();
					write_reg(REG_NONE, 12'hABC);
				end
				send_sample(rand_sample(), 1'b0, '0, 1'b0);
			end
		end

		wait_drained();
		if (mismatches == 0 && pooled_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mps_pkg.sv
hw/rtl/mps_line_bank.sv
hw/rtl/mps_pool_cell.sv
hw/rtl/max_pooling_stream.sv
bench/tb.sv
